// File: src/mlic_pkg.sv
// ----------------------------------------------------------------------------
// mlic_pkg
// Word types, command and register codes, and basic pending layout for the
// masked level interrupt controller.
// ----------------------------------------------------------------------------
package mlic_pkg;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
      logic [63:0] gpu_lines;
      logic [7:0]  arm_lines;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_out;
      logic        fiq_out;
   } rsp_word_type;

   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;

   localparam logic [3:0] REG_BASIC = 4'd0;
   localparam logic [3:0] REG_PEND1 = 4'd1;
   localparam logic [3:0] REG_PEND2 = 4'd2;
   localparam logic [3:0] REG_FIQ   = 4'd3;
   localparam logic [3:0] REG_EN1   = 4'd4;
   localparam logic [3:0] REG_EN2   = 4'd5;
   localparam logic [3:0] REG_ENB   = 4'd6;
   localparam logic [3:0] REG_DIS1  = 4'd7;
   localparam logic [3:0] REG_DIS2  = 4'd8;
   localparam logic [3:0] REG_DISB  = 4'd9;

   localparam int FIQ_ON_BIT = 7;
   localparam logic [6:0] FIQ_SOURCES = 7'd72;

   localparam logic [31:0] SHORT1_MASK = 32'h000C_0680;
   localparam logic [31:0] SHORT2_MASK = 32'h43E0_0000;

   localparam int BASIC_BANK1_BIT = 8;
   localparam int BASIC_BANK2_BIT = 9;
   localparam int BASIC_SHORT_LSB = 10;
   localparam int SHORTCUT_COUNT  = 11;

   localparam logic [5:0] SHORTCUT_POS [SHORTCUT_COUNT] = '{
      6'd7, 6'd9, 6'd10, 6'd18, 6'd19, 6'd53, 6'd54, 6'd55, 6'd56, 6'd57, 6'd62
   };

endpackage

// File: src/mlic_core.sv
// ----------------------------------------------------------------------------
// mlic_core
// Enable, level and FIQ control registers with the single-pass update and
// readback logic for one staged request word.
// ----------------------------------------------------------------------------
module mlic_core
   import mlic_pkg::*;
#(
   parameter int GPU_SOURCES = 64,
   parameter int ARM_SOURCES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type item,
   output rsp_word_type result
);

   localparam logic [63:0] GpuMask = (GPU_SOURCES >= 64) ? {64{1'b1}} :
                                     ((64'd1 << GPU_SOURCES) - 64'd1);
   localparam logic [7:0]  ArmMask = (ARM_SOURCES >= 8) ? 8'hFF :
                                     8'(((9'd1 << ARM_SOURCES) - 9'd1));

   logic [63:0] gpu_enable_ff, gpu_enable_in;
   logic [7:0]  arm_enable_ff, arm_enable_in;
   logic [7:0]  fiq_setting_ff, fiq_setting_in;
   logic [63:0] gpu_level_ff, gpu_level_in;
   logic [7:0]  arm_level_ff, arm_level_in;

   logic [63:0] gpu_pend;
   logic [7:0]  arm_pend;
   logic [31:0] basic;
   logic [71:0] fiq_lines;
   logic [6:0]  fiq_sel;
   logic        fiq;

   always_comb begin
      gpu_enable_in  = gpu_enable_ff;
      arm_enable_in  = arm_enable_ff;
      fiq_setting_in = fiq_setting_ff;
      gpu_level_in   = gpu_level_ff;
      arm_level_in   = arm_level_ff;
      if (item.command == CMD_UPDATE) begin
         gpu_level_in = item.gpu_lines & GpuMask;
         arm_level_in = item.arm_lines & ArmMask;
      end else if (item.command == CMD_WRITE) begin
         unique case (item.reg_index)
            REG_FIQ:  fiq_setting_in = item.write_data[7:0];
            REG_EN1:  gpu_enable_in = gpu_enable_ff | ({32'd0, item.write_data} & GpuMask);
            REG_EN2:  gpu_enable_in = gpu_enable_ff | ({item.write_data, 32'd0} & GpuMask);
            REG_ENB:  arm_enable_in = arm_enable_ff | (item.write_data[7:0] & ArmMask);
            REG_DIS1: gpu_enable_in = gpu_enable_ff & ~{32'd0, item.write_data};
            REG_DIS2: gpu_enable_in = gpu_enable_ff & ~{item.write_data, 32'd0};
            REG_DISB: arm_enable_in = arm_enable_ff & ~item.write_data[7:0];
            default:  ;
         endcase
      end
   end

   // readback reflects the state after this word
   always_comb begin
      gpu_pend = gpu_level_in & gpu_enable_in;
      arm_pend = arm_level_in & arm_enable_in;
      basic = 32'd0;
      basic[7:0] = arm_pend;
      basic[BASIC_BANK1_BIT] = |(gpu_pend[31:0] & ~SHORT1_MASK);
      basic[BASIC_BANK2_BIT] = |(gpu_pend[63:32] & ~SHORT2_MASK);
      for (int i = 0; i < SHORTCUT_COUNT; i++) begin
         basic[BASIC_SHORT_LSB + i] = gpu_pend[SHORTCUT_POS[i]];
      end
   end

   always_comb begin
      fiq_lines = {arm_level_in, gpu_level_in};
      fiq_sel   = fiq_setting_in[6:0];
      fiq       = 1'b0;
      if (fiq_setting_in[FIQ_ON_BIT] && (fiq_sel < FIQ_SOURCES)) begin
         fiq = fiq_lines[fiq_sel];
      end
   end

   always_comb begin
      result.read_data = 32'd0;
      if (item.command == CMD_READ) begin
         unique case (item.reg_index) inside
            REG_BASIC:          result.read_data = basic;
            REG_PEND1:          result.read_data = gpu_pend[31:0];
            REG_PEND2:          result.read_data = gpu_pend[63:32];
            REG_FIQ:            result.read_data = {24'd0, fiq_setting_in};
            REG_EN1, REG_DIS1:  result.read_data = gpu_enable_in[31:0];
            REG_EN2, REG_DIS2:  result.read_data = gpu_enable_in[63:32];
            REG_ENB, REG_DISB:  result.read_data = {24'd0, arm_enable_in};
            default:            result.read_data = 32'd0;
         endcase
      end
      result.irq_out = (|gpu_pend) || (|arm_pend);
      result.fiq_out = fiq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpu_enable_ff  <= '0;
         arm_enable_ff  <= '0;
         fiq_setting_ff <= '0;
         gpu_level_ff   <= '0;
         arm_level_ff   <= '0;
      end else if (fire) begin
         gpu_enable_ff  <= gpu_enable_in;
         arm_enable_ff  <= arm_enable_in;
         fiq_setting_ff <= fiq_setting_in;
         gpu_level_ff   <= gpu_level_in;
         arm_level_ff   <= arm_level_in;
      end
   end

   a_enable_in_range: assert property (@(posedge clock) disable iff (reset)
      ((gpu_enable_ff & ~GpuMask) == 64'd0) && ((arm_enable_ff & ~ArmMask) == 8'd0))
      else $error("enable bit set beyond configured sources");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      ((gpu_level_ff & ~GpuMask) == 64'd0) && ((arm_level_ff & ~ArmMask) == 8'd0))
      else $error("level bit set beyond configured sources");

   a_read_only_data: assert property (@(posedge clock) disable iff (reset)
      (item.command != CMD_READ) |-> (result.read_data == 32'd0))
      else $error("nonzero read data on non-read word");

   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.command == CMD_READ)) |=>
         ($stable(gpu_enable_ff) && $stable(arm_enable_ff) && $stable(fiq_setting_ff)
          && $stable(gpu_level_ff) && $stable(arm_level_ff)))
      else $error("state changed on register read");

endmodule

// File: src/masked_level_interrupt_controller.sv
// ----------------------------------------------------------------------------
// masked_level_interrupt_controller
// Banked level-sensitive interrupt controller with enable set/clear registers,
// pending readback, irq summary and FIQ source select.
// ----------------------------------------------------------------------------
// One request word is taken every clock while rsp_stall is low; each word
// passes through the input register, then the response register, which is
// loaded once it is free; rsp_valid rises when the response register holds
// the response. Register access and line sampling each take one pass
// through the mlic_core logic, which updates state and forms the response
// from the updated state. req_stall rises only while both the input register
// and the response register are full and the response is held off.
module masked_level_interrupt_controller
   import mlic_pkg::*;
#(
   parameter int GPU_SOURCES = 64,
   parameter int ARM_SOURCES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         stage_valid_ff, stage_valid_in;
   req_word_type stage_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type result;
   logic         out_free;
   logic         fire;
   logic         req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign stage_valid_in = req_take || (stage_valid_ff && !fire);
   assign rsp_valid_in   = fire || (rsp_valid_ff && rsp_stall);

   mlic_core #(
      .GPU_SOURCES(GPU_SOURCES),
      .ARM_SOURCES(ARM_SOURCES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (stage_word_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_word_ff <= req_word;
      end
      if (fire) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_take |=> stage_valid_ff)
      else $error("accepted word not staged");

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word lost before response register");

   a_blocked_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !out_free) |=> (stage_valid_ff && $stable(stage_word_ff)))
      else $error("blocked staged word dropped or changed");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register reads, enable set/clear writes, FIQ select writes and line
// updates into the interrupt controller, predicts every response word from
// its own copy of the enable, level and FIQ state, and compares each field.
// Directed words cover reset values, bank summaries, shortcut copies, FIQ
// select range and unused codes; then random traffic with idle and stall
// bursts, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;
   import mlic_pkg::*;

   localparam logic [1:0] CMD_NONE      = 2'd3;
   localparam logic [3:0] REG_UNUSED_LO = 4'd10;
   localparam logic [3:0] REG_UNUSED_HI = 4'd15;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 10;
   localparam int SHORTCUT_BITS [11] = '{7, 9, 10, 18, 19, 53, 54, 55, 56, 57, 62};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // predicted controller state
   logic [63:0] gpu_enable  = '0;
   logic [7:0]  arm_enable  = '0;
   logic [7:0]  fiq_setting = '0;
   logic [63:0] gpu_level   = '0;
   logic [7:0]  arm_level   = '0;

   rsp_word_type predicted_replies [$];
   int errors = 0;
   int cycle_count = 0;
   bit idling = 1'b1;
   int stall_left = 0;

   masked_level_interrupt_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic rsp_word_type predict_reply(req_word_type w);
      rsp_word_type r;
      logic [63:0]  gp;
      logic [6:0]   sel;
      r = '0;
      case (w.command)
         CMD_UPDATE: begin
            gpu_level = w.gpu_lines;
            arm_level = w.arm_lines;
         end
         CMD_WRITE: begin
            case (w.reg_index)
               REG_FIQ:  fiq_setting = w.write_data[7:0];
               REG_EN1:  gpu_enable[31:0]  |= w.write_data;
               REG_EN2:  gpu_enable[63:32] |= w.write_data;
               REG_ENB:  arm_enable        |= w.write_data[7:0];
               REG_DIS1: gpu_enable[31:0]  &= ~w.write_data;
               REG_DIS2: gpu_enable[63:32] &= ~w.write_data;
               REG_DISB: arm_enable        &= ~w.write_data[7:0];
               default: ;
            endcase
         end
         default: ;
      endcase
      gp = gpu_level & gpu_enable;
      if (w.command == CMD_READ) begin
         case (w.reg_index)
            REG_BASIC: begin
               r.read_data[7:0] = arm_level & arm_enable;
               r.read_data[BASIC_BANK1_BIT] = |(gp[31:0] & ~SHORT1_MASK);
               r.read_data[BASIC_BANK2_BIT] = |(gp[63:32] & ~SHORT2_MASK);
               for (int i = 0; i < 11; i++)
                  r.read_data[BASIC_SHORT_LSB + i] = gp[SHORTCUT_BITS[i]];
            end
            REG_PEND1:          r.read_data = gp[31:0];
            REG_PEND2:          r.read_data = gp[63:32];
            REG_FIQ:            r.read_data = {24'b0, fiq_setting};
            REG_EN1, REG_DIS1:  r.read_data = gpu_enable[31:0];
            REG_EN2, REG_DIS2:  r.read_data = gpu_enable[63:32];
            REG_ENB, REG_DISB:  r.read_data = {24'b0, arm_enable};
            default:            r.read_data = '0;
         endcase
      end
      r.irq_out = (|gp) || (|(arm_level & arm_enable));
      sel = fiq_setting[6:0];
      if (fiq_setting[7]) begin
         if (sel < 7'd64)
            r.fiq_out = gpu_level[sel[5:0]];
         else if (sel < 7'd72)
            r.fiq_out = arm_level[sel[2:0]];
      end
      return r;
   endfunction

   function automatic req_word_type make_word(logic [1:0] cmd, logic [3:0] idx,
                                              logic [31:0] data, logic [63:0] gpu,
                                              logic [7:0] arm);
      req_word_type w;
      w.command    = cmd;
      w.reg_index  = idx;
      w.write_data = data;
      w.gpu_lines  = gpu;
      w.arm_lines  = arm;
      return w;
   endfunction

   function automatic logic [31:0] rand_bits32();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return $urandom & $urandom & $urandom;
         2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         3:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom | $urandom;
      endcase
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted_replies.push_back(predict_reply(w));
   endtask

   // receiver stall bursts
   always @(negedge clock) begin
      if (stall_left == 0 && idling && !reset && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 18);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_replies.size() == 0) begin
            $display("%0t unexpected response word, actual %h", $time, rsp_word);
            errors++;
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_word.read_data !== want.read_data) begin
               $display("%0t read_data: expected %h actual %h", $time,
                        want.read_data, rsp_word.read_data);
               errors++;
            end
            if (rsp_word.irq_out !== want.irq_out) begin
               $display("%0t irq_out: expected %b actual %b", $time,
                        want.irq_out, rsp_word.irq_out);
               errors++;
            end
            if (rsp_word.fiq_out !== want.fiq_out) begin
               $display("%0t fiq_out: expected %b actual %b", $time,
                        want.fiq_out, rsp_word.fiq_out);
               errors++;
            end
         end
      end
   end

   task automatic test_reset_state();
      send_word(make_word(CMD_READ, REG_BASIC, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_FIQ, 32'h0, 64'h0, 8'h0));
   endtask

   task automatic test_enable_set_clear();
      send_word(make_word(CMD_WRITE, REG_EN1, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_EN2, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_ENB, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_UPDATE, REG_BASIC, 32'h0, '1, 8'hFF));
      send_word(make_word(CMD_READ, REG_BASIC, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_PEND1, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_PEND2, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_DIS2, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_DIS1, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_DIS2, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_DISB, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_DISB, 32'h0, 64'h0, 8'h0));
   endtask

   task automatic test_shortcut_layout();
      send_word(make_word(CMD_UPDATE, REG_BASIC, 32'h0, {SHORT2_MASK, SHORT1_MASK}, 8'h0));
      send_word(make_word(CMD_WRITE, REG_EN1, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_EN2, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_BASIC, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_UPDATE, REG_BASIC, 32'h0, ~{SHORT2_MASK, SHORT1_MASK}, 8'hFF));
      send_word(make_word(CMD_READ, REG_BASIC, 32'h0, 64'h0, 8'h0));
   endtask

   task automatic test_fiq_select();
      send_word(make_word(CMD_WRITE, REG_FIQ, 32'h0000_0087, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_FIQ, 32'hFFFF_FFC7, 64'h0, 8'h0));
      send_word(make_word(CMD_WRITE, REG_FIQ, 32'h0000_00FF, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_FIQ, 32'h0, 64'h0, 8'h0));
   endtask

   task automatic test_unused_codes();
      send_word(make_word(CMD_WRITE, REG_UNUSED_HI, 32'hFFFF_FFFF, 64'h0, 8'h0));
      send_word(make_word(CMD_READ, REG_UNUSED_LO, 32'h0, 64'h0, 8'h0));
      send_word(make_word(CMD_NONE, REG_EN1, 32'hFFFF_FFFF, '1, 8'hFF));
   endtask

   task automatic test_random_traffic(input int count);
      req_word_type w;
      int kind;
      for (int n = 0; n < count; n++) begin
         w = make_word(CMD_READ, REG_BASIC, $urandom, {$urandom, $urandom},
                       8'($urandom));
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            w.command   = CMD_UPDATE;
            w.gpu_lines = {rand_bits32(), rand_bits32()};
            w.arm_lines = 8'(rand_bits32());
         end else if (kind < 55) begin
            w.command   = CMD_WRITE;
            w.reg_index = 4'($urandom_range(0, 9));
            if (w.reg_index == REG_FIQ) begin
               w.write_data[7] = ($urandom_range(0, 3) != 0);
               w.write_data[6:0] = ($urandom_range(0, 9) == 0) ?
                                   7'($urandom_range(72, 127)) :
                                   7'($urandom_range(0, 71));
            end else begin
               w.write_data = rand_bits32();
            end
         end else if (kind < 95) begin
            w.reg_index = 4'($urandom_range(0, 9));
         end else if (kind < 98) begin
            w.command   = CMD_NONE;
            w.reg_index = 4'($urandom);
         end else begin
            w.command   = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            w.reg_index = 4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
         end
         send_word(w);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_enable_set_clear();
      test_shortcut_layout();
      test_fiq_select();
      test_unused_codes();
      test_random_traffic(1000);
      idling = 1'b0;
      test_random_traffic(250);

      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
